// ===== design/lmsd_pkg.sv =====
// Shared types and the colour map for the LED matrix scan driver.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package lmsd_pkg;

  // Operation carried by each input word
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;      // capture the accepted input word
    logic mem_write;  // single pixel write of the captured word
    logic fill_write; // one column of a row fill
    logic commit;     // load the result register and advance the scan
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    mode_t mode;      // mode of the captured word
    logic  fill_last; // fill counter sits on the last column
    logic  out_free;  // result register can take a new word
  } ctrl_sts_t;

  // Colour code to RGB, bit2 red, bit1 green, bit0 blue
  function automatic logic [2:0] code_to_rgb(input logic [7:0] code);
    logic [2:0] rgb;
    case (code)
      8'd0:    rgb = 3'b000; // black
      8'd1:    rgb = 3'b100; // red
      8'd2:    rgb = 3'b110; // yellow
      8'd3:    rgb = 3'b010; // green
      8'd4:    rgb = 3'b011; // cyan
      8'd5:    rgb = 3'b001; // blue
      8'd6:    rgb = 3'b101; // purple
      8'd7:    rgb = 3'b111; // white
      default: rgb = 3'b000; // unknown codes show black
    endcase
    return rgb;
  endfunction

endpackage

// ===== design/lmsd_in_if.sv =====
// Input channel of the scan driver: valid/ready plus the request word.
// Depends on lmsd_pkg for the mode type.
`timescale 1ns / 1ps

interface lmsd_in_if;
  logic              valid;
  logic              ready;
  lmsd_pkg::mode_t   mode;
  logic [5:0]        row;
  logic [5:0]        col;
  logic [7:0]        color;

  modport source (output valid, output mode, output row, output col, output color,
                  input ready);
  modport sink   (input valid, input mode, input row, input col, input color,
                  output ready);
endinterface

// ===== design/lmsd_out_if.sv =====
// Output channel of the scan driver: valid/ready plus the result word.
// No dependencies.
`timescale 1ns / 1ps

interface lmsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic [2:0] top_rgb;
  logic [2:0] bottom_rgb;
  logic       shift_pulse;
  logic       latch_pulse;
  logic       blank;
  logic [4:0] row_select;
  logic       frame_done;

  modport source (output valid, output read_value, output top_rgb, output bottom_rgb,
                  output shift_pulse, output latch_pulse, output blank,
                  output row_select, output frame_done, input ready);
  modport sink   (input valid, input read_value, input top_rgb, input bottom_rgb,
                  input shift_pulse, input latch_pulse, input blank,
                  input row_select, input frame_done, output ready);
endinterface

// ===== design/lmsd_ctrl.sv =====
// Sequencing state machine of the scan driver.
// Depends on lmsd_pkg for the command and status structs.
`timescale 1ns / 1ps

module lmsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmsd_pkg::ctrl_sts_t sts,
  output lmsd_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FILL,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // memory reads for read and tick land at the end of this cycle
        cmd.mem_write = (sts.mode == lmsd_pkg::MODE_WRITE);
        state_next    = (sts.mode == lmsd_pkg::MODE_FILL) ? ST_FILL : ST_FINISH;
      end
      ST_FILL: begin
        cmd.fill_write = 1'b1;
        if (sts.fill_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait here while the receiver holds the previous word
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lmsd_datapath.sv =====
// Frame store, scan counters and result register of the scan driver.
// Depends on lmsd_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module lmsd_datapath #(
  parameter int PANEL_COLS  = 64,
  parameter int PANEL_PAIRS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  lmsd_pkg::ctrl_cmd_t cmd,
  output lmsd_pkg::ctrl_sts_t sts,
  lmsd_in_if.sink             request,
  lmsd_out_if.source          response
);

  localparam int ROWS  = 2 * PANEL_PAIRS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(PANEL_COLS);
  localparam int PW    = $clog2(PANEL_PAIRS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  // Captured input word
  lmsd_pkg::mode_t mode_q;
  logic [5:0]      row_q;
  logic [5:0]      col_q;
  logic [7:0]      color_q;
  logic            row_ok_q;
  logic            pix_ok_q;
  logic [CW-1:0]   fill_col;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q   <= request.mode;
      row_q    <= request.row;
      col_q    <= request.col;
      color_q  <= request.color;
      row_ok_q <= int'(request.row) < ROWS;
      pix_ok_q <= (int'(request.row) < ROWS) && (int'(request.col) < PANEL_COLS);
      fill_col <= '0;
    end else if (cmd.fill_write) begin
      fill_col <= fill_col + 1'b1;
    end
  end

  // Scan position and panel control state
  logic [PW-1:0] pair;
  logic [CW-1:0] column;
  logic [4:0]    row_address;
  logic          blank_state;

  // Frame store, one write and two registered reads per cycle
  logic [7:0]    store [DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;
  logic [7:0]    rd_data0;
  logic [7:0]    rd_data1;

  assign wr_en    = (cmd.mem_write && pix_ok_q) || (cmd.fill_write && row_ok_q);
  assign wr_addr  = {RW'(row_q), cmd.fill_write ? fill_col : CW'(col_q)};
  assign rd_addr0 = (mode_q == lmsd_pkg::MODE_READ) ? {RW'(row_q), CW'(col_q)}
                                                    : {RW'(pair), column};
  assign rd_addr1 = {RW'(pair) + RW'(PANEL_PAIRS), column};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= color_q;
    end
    rd_data0 <= store[rd_addr0];
    rd_data1 <= store[rd_addr1];
  end

  // Result of the captured word and the scan state after it
  logic          is_tick;
  logic          col_last;
  logic          pair_last;
  logic [PW-1:0] pair_next;
  logic [CW-1:0] column_next;
  logic [4:0]    row_address_next;
  logic          blank_next;

  assign is_tick   = (mode_q == lmsd_pkg::MODE_TICK);
  assign col_last  = (column == CW'(PANEL_COLS - 1));
  assign pair_last = (pair == PW'(PANEL_PAIRS - 1));

  always_comb begin
    pair_next        = pair;
    column_next      = column;
    row_address_next = row_address;
    blank_next       = blank_state;
    if (is_tick) begin
      if (col_last) begin
        // end of the pair: latch, blank and select the pair just shifted
        column_next      = '0;
        pair_next        = pair_last ? '0 : pair + 1'b1;
        row_address_next = 5'(pair);
        blank_next       = 1'b1;
      end else begin
        column_next = column + 1'b1;
        blank_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair        <= '0;
      column      <= '0;
      row_address <= '0;
      blank_state <= 1'b1;
    end else if (cmd.commit) begin
      pair        <= pair_next;
      column      <= column_next;
      row_address <= row_address_next;
      blank_state <= blank_next;
    end
  end

  // Result register
  logic       out_valid;
  logic [7:0] out_read;
  logic [2:0] out_top;
  logic [2:0] out_bottom;
  logic       out_shift;
  logic       out_latch;
  logic       out_blank;
  logic [4:0] out_row;
  logic       out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_read   <= (mode_q == lmsd_pkg::MODE_READ && pix_ok_q) ? rd_data0 : 8'd0;
      out_top    <= is_tick ? lmsd_pkg::code_to_rgb(rd_data0) : 3'd0;
      out_bottom <= is_tick ? lmsd_pkg::code_to_rgb(rd_data1) : 3'd0;
      out_shift  <= is_tick;
      out_latch  <= is_tick && col_last;
      out_done   <= is_tick && col_last && pair_last;
      out_blank  <= blank_next;
      out_row    <= row_address_next;
    end
  end

  assign response.valid       = out_valid;
  assign response.read_value  = out_read;
  assign response.top_rgb     = out_top;
  assign response.bottom_rgb  = out_bottom;
  assign response.shift_pulse = out_shift;
  assign response.latch_pulse = out_latch;
  assign response.blank       = out_blank;
  assign response.row_select  = out_row;
  assign response.frame_done  = out_done;

  // Status back to the controller
  assign sts.mode      = mode_q;
  assign sts.fill_last = (fill_col == CW'(PANEL_COLS - 1));
  assign sts.out_free  = !out_valid || response.ready;

endmodule

// ===== design/led_matrix_scan_driver.sv =====
// Top level of the LED matrix scan driver: controller plus datapath.
// Depends on lmsd_pkg, lmsd_in_if, lmsd_out_if, lmsd_ctrl, lmsd_datapath.
//
// Usage
//   request carries one word per operation: write pixel, fill row, read
//   pixel or scan tick (mode, row, col, color). response returns exactly
//   one result word per request word, in order.
//   A word is taken when valid and ready are both high at a clock edge.
//   Words are handled one at a time: the controller moves from accept
//   to the frame store access (its read data is registered) and then to
//   forming the result; a row fill walks the store one column per cycle
//   between the access and the result. The result is loaded into an
//   output register once that register is free, and is held there until
//   response.ready is high.
//   While the receiver stalls, the block finishes the word in hand and
//   then holds request.ready low until the result register frees.
//   Reset (rst, synchronous) clears the scan position, selects row pair 0
//   and blanks the panel. The frame store is not cleared: write every
//   pixel before it is read or scanned.
`timescale 1ns / 1ps

module led_matrix_scan_driver #(
  parameter int PANEL_COLS  = 64,
  parameter int PANEL_PAIRS = 32
) (
  input  logic       clk,
  input  logic       rst,
  lmsd_in_if.sink    request,
  lmsd_out_if.source response
);

  lmsd_pkg::ctrl_cmd_t cmd;
  lmsd_pkg::ctrl_sts_t sts;
  logic                in_ready;

  assign request.ready = in_ready;

  lmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmsd_datapath #(
    .PANEL_COLS  (PANEL_COLS),
    .PANEL_PAIRS (PANEL_PAIRS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .request  (request),
    .response (response)
  );

  // A result is only loaded when the output register is free
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("result loaded over an untaken word");

  // One word in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("second word accepted while one is in flight");

  // End of frame is always a latching shift
  a_done_latch: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.frame_done) |->
      (response.latch_pulse && response.shift_pulse))
    else $error("frame_done without latch and shift");

  // Latching blanks the panel
  a_latch_blank: assert property (@(posedge clk) disable iff (rst)
    (response.valid && response.latch_pulse) |-> response.blank)
    else $error("latch without blanking");

endmodule
